// ===== rtl/core/set_assoc_cache_lookup_defines.svh =====
// assertion helpers for the cache lookup block
`ifndef SET_ASSOC_CACHE_LOOKUP_DEFINES_SVH
`define SET_ASSOC_CACHE_LOOKUP_DEFINES_SVH

// same-cycle implication
`define SACL_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SACL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/sacl_pkg.sv =====
package sacl_pkg;

   localparam int WORD_W = 32;
   localparam int ADDR_W = 32;

   localparam int CAPACITY_BYTES_DEF = 4096;
   localparam int WAYS_DEF           = 4;
   localparam int BLOCK_WORDS_DEF    = 4;

   // operation codes
   localparam logic [1:0] OP_READ   = 2'd0;
   localparam logic [1:0] OP_WRITE  = 2'd1;
   localparam logic [1:0] OP_HEADER = 2'd2;
   localparam logic [1:0] OP_FILL   = 2'd3;

   // outcome of one lookup, from the update logic to the sequencer
   typedef struct packed {
      logic       meta_we;
      logic       data_we;
      logic       hit;
      logic       hit_dirty;
      logic [1:0] hit_way;
   } upd_status_type;

   // elaboration-time helper, floor of log2
   function automatic int floor_log2(input int v);
      int r;
      r = 0;
      for (int i = 1; i < 31; i++) begin
         if ((v >> i) > 0) begin
            r = i;
         end
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/set_assoc_cache_lookup.sv =====
// set-associative cache store with tag lookup
// request channel (req_*): one transfer carries op, byte address, way, write word and the
// valid/dirty bits for a header load; accepted when req_valid is high and req_stall low
// response channel (rsp_*): exactly one transfer per request, in request order, holding
// hit, the word read before any write, the dirty bit after the operation and the hit way
// metadata (valid, dirty, tag of every way of a set) sits in one row of a metadata ram,
// the words of one offset across all ways in one row of a data ram; both are read through a register
// timing: the request is taken in idle and both rams are read; on the next cycle the ways
// are compared, and once the response register is free the modified rows are written back
// and the response registered; the block takes no new request until then
// the read-modify-write of one request completes before the next read is issued, so no
// forwarding between requests is needed
// reset: after reset the metadata ram is swept one set per cycle to clear valid and
// dirty bits of every set; req_stall stays high then
// stalling: a held response keeps its value; a request already taken waits in its
// compare step until the response register is free, and req_stall stays high meanwhile
`include "set_assoc_cache_lookup_defines.svh"

module set_assoc_cache_lookup #(
   parameter int CAPACITY_BYTES = sacl_pkg::CAPACITY_BYTES_DEF,
   parameter int WAYS           = sacl_pkg::WAYS_DEF,
   parameter int BLOCK_WORDS    = sacl_pkg::BLOCK_WORDS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_op,
   input  logic [sacl_pkg::ADDR_W-1:0]   req_address,
   input  logic [1:0]                    req_way,
   input  logic [sacl_pkg::WORD_W-1:0]   req_write_data,
   input  logic                          req_valid_in,
   input  logic                          req_dirty_in,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_hit,
   output logic [sacl_pkg::WORD_W-1:0]   rsp_read_data,
   output logic                          rsp_hit_dirty,
   output logic [1:0]                    rsp_hit_way
);

   // geometry, floors of log2 for sizes that are not powers of two
   localparam int NUM_BLOCKS  = CAPACITY_BYTES / 4 / BLOCK_WORDS;
   localparam int SETS_RAW    = NUM_BLOCKS / WAYS;
   localparam int SETS        = (SETS_RAW > 0) ? SETS_RAW : 1;
   localparam int OFF_BITS    = sacl_pkg::floor_log2(BLOCK_WORDS);
   localparam int SET_BITS    = sacl_pkg::floor_log2(SETS);
   localparam int SET_SHIFT   = 2 + OFF_BITS;
   localparam int TAG_W       = 32 - SET_SHIFT - SET_BITS;
   localparam int ENTRY_W     = TAG_W + 2;
   localparam int META_W      = WAYS * ENTRY_W;
   localparam int DROW_W      = WAYS * sacl_pkg::WORD_W;
   localparam int META_DEPTH  = 1 << SET_BITS;
   localparam int META_AW     = (SET_BITS > 0) ? SET_BITS : 1;
   localparam int DATA_DEPTH  = 1 << (SET_BITS + OFF_BITS);
   localparam int DATA_AW     = ((SET_BITS + OFF_BITS) > 0) ? (SET_BITS + OFF_BITS) : 1;
   localparam logic [31:0] SET_MASK  = (32'd1 << SET_BITS) - 32'd1;
   localparam logic [31:0] DATA_MASK = (32'd1 << (SET_BITS + OFF_BITS)) - 32'd1;

   // sequencer states
   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_LOOK  = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [META_AW-1:0]  clr_cnt_ff, clr_cnt_in;
   logic                accept;
   logic                finish;

   // request held for the compare step
   logic [1:0]                    op_ff;
   logic [sacl_pkg::ADDR_W-1:0]   address_ff;
   logic [1:0]                    way_ff;
   logic [sacl_pkg::WORD_W-1:0]   write_data_ff;
   logic                          valid_in_ff;
   logic                          dirty_in_ff;

   // response register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_hit_ff;
   logic [sacl_pkg::WORD_W-1:0]   rsp_read_data_ff;
   logic                          rsp_hit_dirty_ff;
   logic [1:0]                    rsp_hit_way_ff;

   // ram ports
   logic                 meta_we, meta_re;
   logic [META_AW-1:0]   meta_waddr, meta_raddr;
   logic [META_W-1:0]    meta_wdata, meta_rdata, meta_new;
   logic                 data_we;
   logic [DATA_AW-1:0]   data_waddr, data_raddr;
   logic [DROW_W-1:0]    data_rdata, data_new;
   logic [sacl_pkg::WORD_W-1:0] upd_read_data;
   sacl_pkg::upd_status_type    upd_status;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   // the compare step completes once the response register is free
   assign finish    = (state_ff == ST_LOOK) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + META_AW'(1);
            if (clr_cnt_ff == META_AW'(META_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (finish) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff         <= req_op;
         address_ff    <= req_address;
         way_ff        <= req_way;
         write_data_ff <= req_write_data;
         valid_in_ff   <= req_valid_in;
         dirty_in_ff   <= req_dirty_in;
      end
   end

   // rams are read only when a request is taken, so the read rows hold through a stall
   assign meta_re    = accept;
   assign meta_raddr = META_AW'((req_address >> SET_SHIFT) & SET_MASK);
   assign data_raddr = DATA_AW'((req_address >> 2) & DATA_MASK);

   // the clearing sweep owns the metadata write port until it is done
   always_comb begin
      if (state_ff == ST_CLEAR) begin
         meta_we    = 1'b1;
         meta_waddr = clr_cnt_ff;
         meta_wdata = '0;
      end else begin
         meta_we    = finish && upd_status.meta_we;
         meta_waddr = META_AW'((address_ff >> SET_SHIFT) & SET_MASK);
         meta_wdata = meta_new;
      end
   end

   assign data_we    = finish && upd_status.data_we;
   assign data_waddr = DATA_AW'((address_ff >> 2) & DATA_MASK);

   sacl_ram #(
      .WIDTH (META_W),
      .DEPTH (META_DEPTH)
   ) u_meta_ram (
      .clock (clock),
      .we    (meta_we),
      .waddr (meta_waddr),
      .wdata (meta_wdata),
      .re    (meta_re),
      .raddr (meta_raddr),
      .rdata (meta_rdata)
   );

   sacl_ram #(
      .WIDTH (DROW_W),
      .DEPTH (DATA_DEPTH)
   ) u_data_ram (
      .clock (clock),
      .we    (data_we),
      .waddr (data_waddr),
      .wdata (data_new),
      .re    (accept),
      .raddr (data_raddr),
      .rdata (data_rdata)
   );

   // way compare and row modification
   sacl_update #(
      .CAPACITY_BYTES (CAPACITY_BYTES),
      .WAYS           (WAYS),
      .BLOCK_WORDS    (BLOCK_WORDS)
   ) u_update (
      .op           (op_ff),
      .address      (address_ff),
      .way          (way_ff),
      .write_data   (write_data_ff),
      .valid_in     (valid_in_ff),
      .dirty_in     (dirty_in_ff),
      .meta_row     (meta_rdata),
      .data_row     (data_rdata),
      .meta_row_new (meta_new),
      .data_row_new (data_new),
      .read_data    (upd_read_data),
      .status       (upd_status)
   );

   // response register: loaded by a finished request, held while stalled
   assign rsp_valid_in = finish || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_hit_ff       <= upd_status.hit;
         rsp_read_data_ff <= upd_read_data;
         rsp_hit_dirty_ff <= upd_status.hit_dirty;
         rsp_hit_way_ff   <= upd_status.hit_way;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit       = rsp_hit_ff;
   assign rsp_read_data = rsp_read_data_ff;
   assign rsp_hit_dirty = rsp_hit_dirty_ff;
   assign rsp_hit_way   = rsp_hit_way_ff;

   // checks
   `SACL_ASSERT_NEXT(a_accept_to_look, clock, reset, accept, state_ff == ST_LOOK, "no compare step")
   `SACL_ASSERT_IMPL(a_rsp_from_look, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_LOOK, "stray response")
   `SACL_ASSERT_IMPL(a_no_meta_overlap, clock, reset, meta_re, !meta_we, "meta read and write overlap")

endmodule

// ===== rtl/core/sacl_ram.sv =====
module sacl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic                                   re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/sacl_update.sv =====
module sacl_update #(
   parameter int CAPACITY_BYTES = sacl_pkg::CAPACITY_BYTES_DEF,
   parameter int WAYS           = sacl_pkg::WAYS_DEF,
   parameter int BLOCK_WORDS    = sacl_pkg::BLOCK_WORDS_DEF
) (
   input  logic [1:0]                        op,
   input  logic [sacl_pkg::ADDR_W-1:0]       address,
   input  logic [1:0]                        way,
   input  logic [sacl_pkg::WORD_W-1:0]       write_data,
   input  logic                              valid_in,
   input  logic                              dirty_in,
   input  logic [WAYS*(32 - 2 - sacl_pkg::floor_log2(BLOCK_WORDS)
                - sacl_pkg::floor_log2(((CAPACITY_BYTES / 4 / BLOCK_WORDS / WAYS) > 0)
                  ? (CAPACITY_BYTES / 4 / BLOCK_WORDS / WAYS) : 1) + 2)-1:0] meta_row,
   input  logic [WAYS*sacl_pkg::WORD_W-1:0]  data_row,
   output logic [WAYS*(32 - 2 - sacl_pkg::floor_log2(BLOCK_WORDS)
                - sacl_pkg::floor_log2(((CAPACITY_BYTES / 4 / BLOCK_WORDS / WAYS) > 0)
                  ? (CAPACITY_BYTES / 4 / BLOCK_WORDS / WAYS) : 1) + 2)-1:0] meta_row_new,
   output logic [WAYS*sacl_pkg::WORD_W-1:0]  data_row_new,
   output logic [sacl_pkg::WORD_W-1:0]       read_data,
   output sacl_pkg::upd_status_type          status
);

   localparam int NUM_BLOCKS = CAPACITY_BYTES / 4 / BLOCK_WORDS;
   localparam int SETS_RAW   = NUM_BLOCKS / WAYS;
   localparam int SETS       = (SETS_RAW > 0) ? SETS_RAW : 1;
   localparam int OFF_BITS   = sacl_pkg::floor_log2(BLOCK_WORDS);
   localparam int SET_BITS   = sacl_pkg::floor_log2(SETS);
   localparam int SET_SHIFT  = 2 + OFF_BITS;
   localparam int TAG_W      = 32 - SET_SHIFT - SET_BITS;
   localparam int ENTRY_W    = TAG_W + 2;
   localparam int WAY_AW     = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam logic [31:0] SET_MASK = (32'd1 << SET_BITS) - 32'd1;

   // entry layout: valid, dirty, tag
   localparam int DIRTY_POS = TAG_W;
   localparam int VALID_POS = TAG_W + 1;

   logic [TAG_W-1:0]  tag;
   logic [31:0]       set_val;
   logic [31:0]       blk_base;
   logic [WAYS-1:0]   match;
   logic              hit;
   logic [WAY_AW-1:0] hit_idx;
   logic              way_ok;
   logic [ENTRY_W-1:0] hit_entry;

   assign tag      = address[sacl_pkg::ADDR_W-1 -: TAG_W];
   assign set_val  = (address >> SET_SHIFT) & SET_MASK;
   assign blk_base = set_val * 32'(WAYS);

   // ways beyond the end of the store never match
   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         match[w] = meta_row[w*ENTRY_W + VALID_POS]
                 && (meta_row[w*ENTRY_W +: TAG_W] == tag)
                 && ((blk_base + 32'(w)) < 32'(NUM_BLOCKS));
      end
   end

   // lowest matching way wins
   always_comb begin
      hit     = 1'b0;
      hit_idx = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (match[w]) begin
            hit     = 1'b1;
            hit_idx = WAY_AW'(w);
         end
      end
   end

   assign hit_entry = meta_row[hit_idx*ENTRY_W +: ENTRY_W];
   assign way_ok    = ({30'b0, way} < 32'(WAYS))
                   && ((blk_base + {30'b0, way}) < 32'(NUM_BLOCKS));

   always_comb begin
      meta_row_new = meta_row;
      data_row_new = data_row;
      read_data    = '0;
      status       = '0;
      unique case (op)
         sacl_pkg::OP_READ: begin
            if (hit) begin
               status.hit       = 1'b1;
               status.hit_way   = 2'(hit_idx);
               status.hit_dirty = hit_entry[DIRTY_POS];
               read_data        = data_row[hit_idx*sacl_pkg::WORD_W +: sacl_pkg::WORD_W];
            end
         end
         sacl_pkg::OP_WRITE: begin
            if (hit) begin
               status.hit       = 1'b1;
               status.hit_way   = 2'(hit_idx);
               status.hit_dirty = 1'b1;
               status.meta_we   = 1'b1;
               status.data_we   = 1'b1;
               read_data        = data_row[hit_idx*sacl_pkg::WORD_W +: sacl_pkg::WORD_W];
               data_row_new[hit_idx*sacl_pkg::WORD_W +: sacl_pkg::WORD_W] = write_data;
               meta_row_new[hit_idx*ENTRY_W + DIRTY_POS] = 1'b1;
            end
         end
         sacl_pkg::OP_HEADER: begin
            if (way_ok) begin
               status.meta_we = 1'b1;
               meta_row_new[way*ENTRY_W +: ENTRY_W] = {valid_in, dirty_in, tag};
            end
         end
         sacl_pkg::OP_FILL: begin
            if (way_ok) begin
               status.data_we = 1'b1;
               data_row_new[way*sacl_pkg::WORD_W +: sacl_pkg::WORD_W] = write_data;
            end
         end
         default: begin
            status = '0;
         end
      endcase
   end

endmodule

// ===== tb/tb_set_assoc_cache_lookup.sv =====
`timescale 1ns / 100ps

module tb_set_assoc_cache_lookup;
   import sacl_pkg::*;

   // geometry of the default build
   localparam int WAYS        = WAYS_DEF;
   localparam int BLOCK_WORDS = BLOCK_WORDS_DEF;
   localparam int NUM_WORDS   = CAPACITY_BYTES_DEF / 4;
   localparam int NUM_BLOCKS  = NUM_WORDS / BLOCK_WORDS;
   localparam int NUM_SETS    = NUM_BLOCKS / WAYS;
   localparam int OFF_W       = $clog2(BLOCK_WORDS);
   localparam int SET_W       = $clog2(NUM_SETS);
   localparam int SET_LSB     = 2 + OFF_W;
   localparam int TAG_LSB     = SET_LSB + SET_W;
   localparam int TAG_W       = ADDR_W - TAG_LSB;

   localparam int MAX_REPORTS = 10;
   localparam int QUIET_LIMIT = 2000;   // cycles with no transfer on either channel
   localparam int HOLD_CYCLES = 80;     // long receiver hold-off
   localparam int TAG_POOL    = 6;
   localparam int SET_POOL    = 8;

   typedef struct {
      logic [1:0]        op;
      logic [ADDR_W-1:0] address;
      logic [1:0]        way;
      logic [WORD_W-1:0] write_data;
      logic              valid_in;
      logic              dirty_in;
   } cache_req_type;

   typedef struct {
      logic              hit;
      logic [WORD_W-1:0] read_data;
      logic              hit_dirty;
      logic [1:0]        hit_way;
   } cache_rsp_type;

   // shadow copy of the cache contents plus the queue of responses still owed
   class cache_shadow;
      bit              line_valid[NUM_BLOCKS];
      bit              line_dirty[NUM_BLOCKS];
      bit [TAG_W-1:0]  line_tag[NUM_BLOCKS];
      bit [WORD_W-1:0] words[NUM_WORDS];
      bit              word_written[NUM_WORDS];
      cache_rsp_type   due_responses[$];
      int              mismatches;
      int              responses;

      function int line_of(cache_req_type r, int w);
         return int'(r.address[SET_LSB +: SET_W]) * WAYS + w;
      endfunction

      function int word_of(cache_req_type r, int w);
         return line_of(r, w) * BLOCK_WORDS + int'(r.address[2 +: OFF_W]);
      endfunction

      // lowest valid way whose tag matches, -1 on a miss
      function int match_way(cache_req_type r);
         for (int w = 0; w < WAYS; w++) begin
            if (line_valid[line_of(r, w)] &&
                line_tag[line_of(r, w)] == r.address[ADDR_W-1:TAG_LSB])
               return w;
         end
         return -1;
      endfunction

      // would this lookup hit a word that was never stored
      function bit hits_blank_word(cache_req_type r, output logic [1:0] way_out);
         int w;
         w = match_way(r);
         way_out = w[1:0];
         return (w >= 0) && !word_written[word_of(r, w)];
      endfunction

      function void note_access(cache_req_type r);
         cache_rsp_type e;
         int            w;
         int            b;
         int            wi;
         e = '{hit: 1'b0, read_data: '0, hit_dirty: 1'b0, hit_way: 2'd0};
         case (r.op)
            OP_READ, OP_WRITE: begin
               w = match_way(r);
               if (w >= 0) begin
                  b  = line_of(r, w);
                  wi = word_of(r, w);
                  e.hit       = 1'b1;
                  e.hit_way   = w[1:0];
                  e.read_data = words[wi];
                  if (r.op == OP_WRITE) begin
                     words[wi]        = r.write_data;
                     word_written[wi] = 1'b1;
                     line_dirty[b]    = 1'b1;
                  end
                  e.hit_dirty = line_dirty[b];
               end
            end
            OP_HEADER: begin
               b = line_of(r, int'(r.way));
               line_valid[b] = r.valid_in;
               line_dirty[b] = r.dirty_in;
               line_tag[b]   = r.address[ADDR_W-1:TAG_LSB];
            end
            default: begin
               wi = word_of(r, int'(r.way));
               words[wi]        = r.write_data;
               word_written[wi] = 1'b1;
            end
         endcase
         due_responses.push_back(e);
      endfunction

      function void check_response(cache_rsp_type got);
         cache_rsp_type want;
         responses++;
         if (due_responses.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("response %0d arrived with no request outstanding", responses);
            return;
         end
         want = due_responses.pop_front();
         if (got.hit !== want.hit || got.read_data !== want.read_data ||
             got.hit_dirty !== want.hit_dirty || got.hit_way !== want.hit_way) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display({"response %0d mismatch: hit %0b/%0b data %h/%h dirty %0b/%0b ",
                         "way %0d/%0d (exp/got)"},
                        responses, want.hit, got.hit, want.read_data, got.read_data,
                        want.hit_dirty, got.hit_dirty, want.hit_way, got.hit_way);
         end
      endfunction

      function int outstanding();
         return due_responses.size();
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [1:0]        req_op;
   logic [ADDR_W-1:0] req_address;
   logic [1:0]        req_way;
   logic [WORD_W-1:0] req_write_data;
   logic              req_valid_in;
   logic              req_dirty_in;
   logic              rsp_valid;
   logic              rsp_stall;
   logic              rsp_hit;
   logic [WORD_W-1:0] rsp_read_data;
   logic              rsp_hit_dirty;
   logic [1:0]        rsp_hit_way;

   cache_shadow       shadow;
   int                snd_idle_pct;
   int                rcv_idle_pct;
   bit                hold_rsp;
   logic [TAG_W-1:0]  tag_pool[TAG_POOL];
   logic [SET_W-1:0]  set_pool[SET_POOL];
   cache_req_type     directed[$];

   set_assoc_cache_lookup u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_address    (req_address),
      .req_way        (req_way),
      .req_write_data (req_write_data),
      .req_valid_in   (req_valid_in),
      .req_dirty_in   (req_dirty_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hit        (rsp_hit),
      .rsp_read_data  (rsp_read_data),
      .rsp_hit_dirty  (rsp_hit_dirty),
      .rsp_hit_way    (rsp_hit_way)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic cache_req_type mk(logic [1:0] op, logic [ADDR_W-1:0] a, logic [1:0] w,
                                        logic [WORD_W-1:0] d, logic v, logic dr);
      cache_req_type r;
      r.op         = op;
      r.address    = a;
      r.way        = w;
      r.write_data = d;
      r.valid_in   = v;
      r.dirty_in   = dr;
      return r;
   endfunction

   // addresses mostly fall on a few tags and sets so that lookups collide and hit
   function automatic logic [ADDR_W-1:0] random_address();
      logic [TAG_W-1:0]   tag_bits;
      logic [SET_W-1:0]   set_idx;
      logic [SET_LSB-1:0] low_bits;
      logic [31:0]        raw;
      raw = $urandom;
      if ($urandom_range(99) < 80)
         tag_bits = tag_pool[$urandom_range(TAG_POOL-1)];
      else
         tag_bits = raw[TAG_W-1:0];
      raw = $urandom;
      if ($urandom_range(99) < 70)
         set_idx = set_pool[$urandom_range(SET_POOL-1)];
      else
         set_idx = raw[SET_W-1:0];
      raw = $urandom;
      low_bits = raw[SET_LSB-1:0];
      return {tag_bits, set_idx, low_bits};
   endfunction

   function automatic cache_req_type random_access();
      int         pick;
      logic [1:0] op;
      pick = $urandom_range(99);
      if (pick < 35)
         op = OP_READ;
      else if (pick < 60)
         op = OP_WRITE;
      else if (pick < 75)
         op = OP_HEADER;
      else
         op = OP_FILL;
      return mk(op, random_address(), 2'($urandom_range(3)), $urandom,
                $urandom_range(99) < 85, 1'($urandom_range(1)));
   endfunction

   // one transfer on the request channel; random gaps first, then hold until taken
   task automatic issue_access(cache_req_type item);
      logic [1:0] blank_way;
      while ($urandom_range(99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      // a hit on a word never stored has no defined answer, so store it instead
      if ((item.op == OP_READ || item.op == OP_WRITE) &&
          shadow.hits_blank_word(item, blank_way)) begin
         item.op  = OP_FILL;
         item.way = blank_way;
      end
      req_valid      <= 1'b1;
      req_op         <= item.op;
      req_address    <= item.address;
      req_way        <= item.way;
      req_write_data <= item.write_data;
      req_valid_in   <= item.valid_in;
      req_dirty_in   <= item.dirty_in;
      do @(posedge clock); while (req_stall);
      shadow.note_access(item);
   endtask

   // sender pause: nothing offered until every owed response has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (shadow.outstanding() > 0);
   endtask

   // well-formed line load: header, every word of the block, then a couple of lookups
   task automatic load_line(output int issued);
      cache_req_type     r;
      logic [ADDR_W-1:0] base_addr;
      logic [1:0]        w;
      logic [OFF_W-1:0]  off;
      base_addr = random_address();
      w = 2'($urandom_range(3));
      issue_access(mk(OP_HEADER, base_addr, w, $urandom, 1'b1, 1'($urandom_range(1))));
      for (int i = 0; i < BLOCK_WORDS; i++) begin
         off = OFF_W'(i);
         r = mk(OP_FILL, {base_addr[ADDR_W-1:SET_LSB], off, base_addr[1:0]}, w, $urandom,
                1'b0, 1'b0);
         issue_access(r);
      end
      for (int i = 0; i < 2; i++) begin
         off = OFF_W'($urandom);
         r = mk($urandom_range(1) ? OP_WRITE : OP_READ,
                {base_addr[ADDR_W-1:SET_LSB], off, 2'($urandom)}, 2'($urandom), $urandom,
                1'b0, 1'b0);
         issue_access(r);
      end
      issued = BLOCK_WORDS + 3;
   endtask

   task automatic run_random(int count);
      int sent;
      int n;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(99) < 30) begin
            load_line(n);
            sent += n;
         end else begin
            issue_access(random_access());
            sent++;
         end
      end
   endtask

   // receiver: random stalls, plus a long hold-off on request so the block backs up
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
            @(posedge clock);
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      cache_rsp_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.hit       = rsp_hit;
         got.read_data = rsp_read_data;
         got.hit_dirty = rsp_hit_dirty;
         got.hit_way   = rsp_hit_way;
         shadow.check_response(got);
      end
   end

   // watchdog: gives up after a long stretch with no transfer at all
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet = 0;
         else
            quiet++;
      end
      $display("[set_assoc_cache_lookup] ERROR");
      $finish;
   end

   initial begin
      logic [ADDR_W-1:0] a_lo;
      logic [ADDR_W-1:0] a_hi;
      logic [ADDR_W-1:0] a_alt;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_op         <= OP_READ;
      req_address    <= '0;
      req_way        <= 2'd0;
      req_write_data <= '0;
      req_valid_in   <= 1'b0;
      req_dirty_in   <= 1'b0;
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      hold_rsp     = 1'b0;
      shadow = new;

      // tag and set pools always include the extremes
      tag_pool[0] = '0;
      tag_pool[1] = '1;
      for (int i = 2; i < TAG_POOL; i++) tag_pool[i] = TAG_W'($urandom);
      set_pool[0] = '0;
      set_pool[1] = '1;
      for (int i = 2; i < SET_POOL; i++) set_pool[i] = SET_W'($urandom);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      a_lo  = 32'h0000_0000;
      a_hi  = 32'hFFFF_FFFF;
      a_alt = a_hi ^ 32'h0000_0400;   // same set as a_hi, different tag
      // lookups on an empty cache miss, a write on a miss changes nothing
      directed.push_back(mk(OP_READ,   a_lo, 2'd0, 32'h0,         1'b0, 1'b0));
      directed.push_back(mk(OP_WRITE,  a_hi, 2'd3, 32'hFFFF_FFFF, 1'b1, 1'b1));
      // load a block into way 2 of set 0
      directed.push_back(mk(OP_HEADER, a_lo, 2'd2, 32'h0,         1'b1, 1'b0));
      directed.push_back(mk(OP_FILL,   a_lo | 32'h0, 2'd2, 32'h0000_0000, 1'b0, 1'b0));
      directed.push_back(mk(OP_FILL,   a_lo | 32'h4, 2'd2, 32'hFFFF_FFFF, 1'b0, 1'b0));
      directed.push_back(mk(OP_FILL,   a_lo | 32'h8, 2'd2, 32'hA5A5_A5A5, 1'b0, 1'b0));
      directed.push_back(mk(OP_FILL,   a_lo | 32'hC, 2'd2, 32'h5A5A_5A5A, 1'b1, 1'b1));
      directed.push_back(mk(OP_READ,   a_lo | 32'h4, 2'd0, 32'h0,         1'b0, 1'b0));
      directed.push_back(mk(OP_WRITE,  a_lo | 32'h8, 2'd0, 32'h1234_5678, 1'b0, 1'b0));
      directed.push_back(mk(OP_READ,   a_lo | 32'h8, 2'd0, 32'h0,         1'b0, 1'b0));
      // same tag in a lower way: the lower way wins
      directed.push_back(mk(OP_HEADER, a_lo, 2'd1, 32'h0,         1'b1, 1'b1));
      directed.push_back(mk(OP_FILL,   a_lo | 32'h8, 2'd1, 32'hDEAD_BEEF, 1'b0, 1'b0));
      directed.push_back(mk(OP_READ,   a_lo | 32'h8, 2'd0, 32'h0,         1'b0, 1'b0));
      // header with valid clear still writes the tag but drops the way out of the lookup
      directed.push_back(mk(OP_HEADER, a_lo, 2'd1, 32'h0,         1'b0, 1'b0));
      directed.push_back(mk(OP_READ,   a_lo | 32'h8, 2'd0, 32'h0,         1'b0, 1'b0));
      // top of the address space, last set, last way
      directed.push_back(mk(OP_HEADER, a_hi, 2'd3, 32'h0,         1'b1, 1'b1));
      directed.push_back(mk(OP_FILL,   a_hi, 2'd3, 32'h0000_0000, 1'b1, 1'b1));
      directed.push_back(mk(OP_READ,   a_hi, 2'd0, 32'h0,         1'b0, 1'b0));
      directed.push_back(mk(OP_WRITE,  a_hi, 2'd0, 32'h0000_0000, 1'b0, 1'b0));
      // another tag in the same set, clean until written
      directed.push_back(mk(OP_HEADER, a_alt, 2'd0, 32'h0,         1'b1, 1'b0));
      directed.push_back(mk(OP_FILL,   a_alt, 2'd0, 32'hFFFF_FFFF, 1'b0, 1'b0));
      directed.push_back(mk(OP_READ,   a_alt, 2'd0, 32'h0,         1'b0, 1'b0));
      directed.push_back(mk(OP_WRITE,  a_alt, 2'd0, 32'h55AA_55AA, 1'b0, 1'b0));
      // the two byte bits are ignored
      directed.push_back(mk(OP_READ,   a_lo | 32'h3, 2'd0, 32'h0,         1'b0, 1'b0));
      foreach (directed[i]) issue_access(directed[i]);
      wait_drained();

      // sender idles less than the receiver; long hold-off part way through
      snd_idle_pct = 31;
      rcv_idle_pct = 49;
      run_random(200);
      hold_rsp = 1'b1;
      run_random(420);
      wait_drained();

      // the other way round
      snd_idle_pct = 49;
      rcv_idle_pct = 31;
      run_random(600);
      wait_drained();

      // back to back, with one more hold-off to fill the pipeline
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      run_random(300);
      hold_rsp = 1'b1;
      run_random(310);

      wait_drained();
      repeat (8) @(posedge clock);
      if (shadow.mismatches == 0 && shadow.outstanding() == 0)
         $display("[set_assoc_cache_lookup] OK");
      else
         $display("[set_assoc_cache_lookup] ERROR");
      $finish;
   end

endmodule
